FILE: hdl/cds_pkg.sv
`default_nettype none
package cds_pkg;

  localparam int MaxProcs = 16;
  localparam int IdxW = $clog2(MaxProcs);
  localparam int CntW = $clog2(MaxProcs + 1);
  localparam int TimeW = 21;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_RESTART  = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_FCFS = 2'd0,
    MODE_SJF  = 2'd1,
    MODE_PRIO = 2'd2,
    MODE_RR   = 2'd3
  } mode_e;

  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NP_DECIDE,
    ST_NP_MIN,
    ST_ADMIT,
    ST_RR_POP,
    ST_RR_IDLE,
    ST_RR_RUN,
    ST_RR_POST,
    ST_RR_FINAL,
    ST_EMIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic do_load;
    logic do_restart;
    logic do_clear;
    logic scan_start;
    logic scan_step;
    logic np_jump;
    logic np_commit;
    logic admit_step;
    logic rr_pop;
    logic rr_jump;
    logic rr_run;
    logic rr_finish;
    logic emit_start;
    logic emit_none;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic best_valid;
    logic any_pending;
    logic admit_done;
    logic ring_empty;
    logic pop_live;
    logic admit_more;
    logic emit_done;
  } status_t;

endpackage
`default_nettype wire

FILE: hdl/cds_ctrl.sv
`default_nettype none
module cds_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_fire_i,
  input  wire logic [1:0]        cmd_i,
  input  wire logic              rr_mode_i,
  input  wire logic              out_busy_i,
  input  wire cds_pkg::status_t  st_i,
  output logic                   in_ready_o,
  output cds_pkg::cmd_t          cmd_o
);

  cds_pkg::state_e state_q, state_d;
  logic rr_second_q, rr_second_d;
  logic np_second_q, np_second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cds_pkg::ST_IDLE;
      rr_second_q <= 1'b0;
      np_second_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rr_second_q <= rr_second_d;
      np_second_q <= np_second_d;
    end
  end

  always_comb begin
    state_d = state_q;
    rr_second_d = rr_second_q;
    np_second_d = np_second_q;
    unique case (state_q)
      cds_pkg::ST_IDLE: begin
        if (in_fire_i && cmd_i == cds_pkg::CMD_DISPATCH) begin
          if (rr_mode_i) begin
            state_d = cds_pkg::ST_ADMIT;
            rr_second_d = 1'b0;
          end else begin
            state_d = cds_pkg::ST_SCAN;
            np_second_d = 1'b0;
          end
        end
      end
      cds_pkg::ST_SCAN: if (st_i.scan_done) state_d = cds_pkg::ST_NP_DECIDE;
      cds_pkg::ST_NP_DECIDE: begin
        if (st_i.best_valid) state_d = cds_pkg::ST_NP_MIN;
        else if (!st_i.any_pending || np_second_q) state_d = cds_pkg::ST_EMIT;
        else begin
          state_d = cds_pkg::ST_SCAN;
          np_second_d = 1'b1;
        end
      end
      cds_pkg::ST_NP_MIN: state_d = cds_pkg::ST_EMIT;
      cds_pkg::ST_ADMIT: begin
        if (st_i.admit_done) begin
          if (rr_second_q) state_d = cds_pkg::ST_RR_FINAL;
          else state_d = cds_pkg::ST_RR_POP;
        end
      end
      cds_pkg::ST_RR_POP: begin
        if (st_i.ring_empty) state_d = cds_pkg::ST_RR_IDLE;
        else if (st_i.pop_live) state_d = cds_pkg::ST_RR_RUN;
      end
      cds_pkg::ST_RR_IDLE: begin
        if (st_i.admit_more) state_d = cds_pkg::ST_ADMIT;
        else state_d = cds_pkg::ST_EMIT;
      end
      cds_pkg::ST_RR_RUN: state_d = cds_pkg::ST_RR_POST;
      cds_pkg::ST_RR_POST: begin
        state_d = cds_pkg::ST_ADMIT;
        rr_second_d = 1'b1;
      end
      cds_pkg::ST_RR_FINAL: state_d = cds_pkg::ST_EMIT;
      cds_pkg::ST_EMIT: if (st_i.emit_done) state_d = cds_pkg::ST_OUT;
      cds_pkg::ST_OUT: if (!out_busy_i) state_d = cds_pkg::ST_IDLE;
      default: state_d = cds_pkg::ST_IDLE;
    endcase
  end

  logic emit_none_q, emit_none_d;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) emit_none_q <= 1'b0;
    else emit_none_q <= emit_none_d;
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    emit_none_d = emit_none_q;
    unique case (state_q)
      cds_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.do_load = cmd_i == cds_pkg::CMD_LOAD;
          cmd_o.do_restart = cmd_i == cds_pkg::CMD_RESTART;
          cmd_o.do_clear = cmd_i == cds_pkg::CMD_CLEAR;
          cmd_o.scan_start = cmd_i == cds_pkg::CMD_DISPATCH && !rr_mode_i;
        end
      end
      cds_pkg::ST_SCAN: cmd_o.scan_step = 1'b1;
      cds_pkg::ST_NP_DECIDE: begin
        if (st_i.best_valid) begin
          emit_none_d = 1'b0;
        end else if (!st_i.any_pending || np_second_q) begin
          cmd_o.emit_start = 1'b1;
          emit_none_d = 1'b1;
        end else begin
          cmd_o.np_jump = 1'b1;
          cmd_o.scan_start = 1'b1;
        end
      end
      cds_pkg::ST_NP_MIN: begin
        cmd_o.np_commit = 1'b1;
        cmd_o.emit_start = 1'b1;
      end
      cds_pkg::ST_ADMIT: cmd_o.admit_step = 1'b1;
      cds_pkg::ST_RR_POP: if (!st_i.ring_empty) cmd_o.rr_pop = 1'b1;
      cds_pkg::ST_RR_IDLE: begin
        if (st_i.admit_more) cmd_o.rr_jump = 1'b1;
        else begin
          cmd_o.emit_start = 1'b1;
          emit_none_d = 1'b1;
        end
      end
      cds_pkg::ST_RR_RUN: cmd_o.rr_run = 1'b1;
      cds_pkg::ST_RR_POST: ;
      cds_pkg::ST_RR_FINAL: begin
        cmd_o.rr_finish = 1'b1;
        cmd_o.emit_start = 1'b1;
        emit_none_d = 1'b0;
      end
      cds_pkg::ST_EMIT: begin
        cmd_o.emit_none = emit_none_q;
        cmd_o.out_load = st_i.emit_done;
      end
      cds_pkg::ST_OUT: ;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/cds_datapath.sv
`default_nettype none
module cds_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cds_pkg::cmd_t     cmd_i,
  input  wire logic [1:0]        mode_i,
  input  wire logic [15:0]       quantum_i,
  input  wire logic [7:0]        proc_id_i,
  input  wire logic [15:0]       arrival_i,
  input  wire logic [15:0]       burst_i,
  input  wire logic [7:0]        prio_i,
  output cds_pkg::status_t       st_o,
  output logic [95:0]            result_o
);

  localparam int IW = cds_pkg::IdxW;
  localparam int CW = cds_pkg::CntW;
  localparam int TW = cds_pkg::TimeW;
  localparam int N  = cds_pkg::MaxProcs;
  localparam int PW = TW - 16;

  logic [7:0]    ids_q   [N];
  logic [15:0]   arr_q   [N];
  logic [15:0]   bur_q   [N];
  logic [7:0]    pri_q   [N];
  logic [15:0]   rem_q   [N];
  logic [IW-1:0] ring_q  [N];
  logic [N-1:0]  done_q;
  logic [CW-1:0] count_q;
  logic [TW-1:0] now_q;
  logic [IW-1:0] head_q;
  logic [CW-1:0] fill_q;
  logic [CW-1:0] admit_q;

  logic [CW-1:0] scan_q;
  logic          best_v_q;
  logic [IW-1:0] best_q;
  logic          any_q;
  logic [15:0]   earliest_q;
  logic [IW-1:0] cur_q;
  logic [TW-1:0] start_q;
  logic [CW-1:0] emit_q;
  logic          all_q;

  logic [IW-1:0] si;
  logic          s_live, s_ready, s_better;
  logic [15:0]   ka, kb;
  assign si = scan_q[IW-1:0];
  assign s_live = scan_q < count_q && !done_q[si];
  assign s_ready = s_live && {{PW{1'b0}}, arr_q[si]} <= now_q;
  always_comb begin
    ka = '0;
    kb = '0;
    if (mode_i == cds_pkg::MODE_SJF) begin
      ka = rem_q[si];
      kb = rem_q[best_q];
    end else if (mode_i == cds_pkg::MODE_PRIO) begin
      ka = {8'd0, pri_q[si]};
      kb = {8'd0, pri_q[best_q]};
    end
    if (ka != kb) s_better = ka < kb;
    else s_better = arr_q[si] < arr_q[best_q];
  end

  logic [IW-1:0] ai;
  logic          admit_avail;
  assign ai = admit_q[IW-1:0];
  assign admit_avail = admit_q < count_q;

  logic [IW-1:0] pop_idx;
  assign pop_idx = ring_q[head_q];

  logic [16:0]   qeff;
  logic [15:0]   run_d;
  logic [TW:0]   sum;
  logic [TW-1:0] end_t;
  assign qeff = (quantum_i == '0) ? 17'd1 : {1'b0, quantum_i};
  assign run_d = ({1'b0, rem_q[cur_q]} < qeff) ? rem_q[cur_q] : qeff[15:0];
  assign sum = {1'b0, now_q} + {{(TW-15){1'b0}}, (cmd_i.np_commit ? rem_q[best_q] : run_d)};
  assign end_t = sum[TW] ? cds_pkg::TimeMax : sum[TW-1:0];

  logic [TW-1:0] tat, wt, arr_w, bur_w;
  assign arr_w = {{PW{1'b0}}, arr_q[cur_q]};
  assign bur_w = {{PW{1'b0}}, bur_q[cur_q]};
  assign tat = now_q >= arr_w ? now_q - arr_w : '0;
  assign wt = tat >= bur_w ? tat - bur_w : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
      count_q <= '0;
      now_q <= '0;
      head_q <= '0;
      fill_q <= '0;
      admit_q <= '0;
      scan_q <= '0;
      best_v_q <= 1'b0;
      any_q <= 1'b0;
      emit_q <= '0;
      all_q <= 1'b1;
    end else begin
      if (cmd_i.do_load && count_q < CW'(N)) begin
        ids_q[count_q[IW-1:0]] <= proc_id_i;
        arr_q[count_q[IW-1:0]] <= arrival_i;
        bur_q[count_q[IW-1:0]] <= burst_i;
        pri_q[count_q[IW-1:0]] <= prio_i;
        rem_q[count_q[IW-1:0]] <= burst_i;
        done_q[count_q[IW-1:0]] <= 1'b0;
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.do_restart || cmd_i.do_clear) begin
        now_q <= '0;
        done_q <= '0;
        head_q <= '0;
        fill_q <= '0;
        admit_q <= '0;
        for (int i = 0; i < N; i++) rem_q[i] <= bur_q[i];
        if (cmd_i.do_clear) count_q <= '0;
      end
      if (cmd_i.np_jump && {{PW{1'b0}}, earliest_q} > now_q) now_q <= {{PW{1'b0}}, earliest_q};
      if (cmd_i.scan_start) begin
        scan_q <= '0;
        best_v_q <= 1'b0;
        any_q <= 1'b0;
      end
      if (cmd_i.scan_step && scan_q < CW'(N)) begin
        scan_q <= scan_q + CW'(1);
        if (s_live) begin
          if (!any_q || arr_q[si] < earliest_q) earliest_q <= arr_q[si];
          any_q <= 1'b1;
        end
        if (s_ready && (!best_v_q || s_better)) begin
          best_v_q <= 1'b1;
          best_q <= si;
        end
      end
      if (cmd_i.np_commit) begin
        cur_q <= best_q;
        start_q <= now_q;
        now_q <= end_t;
        rem_q[best_q] <= '0;
        done_q[best_q] <= 1'b1;
      end
      if (cmd_i.admit_step && admit_avail) begin
        if (done_q[ai]) admit_q <= admit_q + CW'(1);
        else if ({{PW{1'b0}}, arr_q[ai]} <= now_q) begin
          if (fill_q < CW'(N)) begin
            ring_q[head_q + fill_q[IW-1:0]] <= ai;
            fill_q <= fill_q + CW'(1);
          end
          admit_q <= admit_q + CW'(1);
        end
      end
      if (cmd_i.rr_pop) begin
        cur_q <= pop_idx;
        head_q <= head_q + IW'(1);
        fill_q <= fill_q - CW'(1);
      end
      if (cmd_i.rr_jump && {{PW{1'b0}}, arr_q[ai]} > now_q) now_q <= {{PW{1'b0}}, arr_q[ai]};
      if (cmd_i.rr_run) begin
        start_q <= now_q;
        now_q <= end_t;
        rem_q[cur_q] <= rem_q[cur_q] - run_d;
      end
      if (cmd_i.rr_finish) begin
        if (rem_q[cur_q] != '0) begin
          if (fill_q < CW'(N)) begin
            ring_q[head_q + fill_q[IW-1:0]] <= cur_q;
            fill_q <= fill_q + CW'(1);
          end
        end else begin
          done_q[cur_q] <= 1'b1;
        end
      end
      if (cmd_i.emit_start) begin
        emit_q <= '0;
        all_q <= 1'b1;
      end else if (!st_o.emit_done) begin
        emit_q <= emit_q + CW'(1);
        if (emit_q < count_q && !done_q[emit_q[IW-1:0]]) all_q <= 1'b0;
      end
    end
  end

  logic fin_q;
  logic [95:0] res_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.np_commit) fin_q <= 1'b1;
    if (cmd_i.rr_finish) fin_q <= rem_q[cur_q] == '0;
    if (cmd_i.out_load) begin
      if (cmd_i.emit_none) begin
        res_q <= {1'b0, 1'b1, 93'd0, 1'b1};
      end else begin
        res_q <= {1'b0, all_q, (fin_q ? wt : '0), (fin_q ? tat : '0), fin_q,
                  now_q, start_q, ids_q[cur_q], 1'b0};
      end
    end
  end

  assign result_o = res_q;
  assign st_o.scan_done = scan_q >= CW'(N);
  assign st_o.best_valid = best_v_q;
  assign st_o.any_pending = any_q;
  assign st_o.admit_done = !admit_avail || (!done_q[ai] && {{PW{1'b0}}, arr_q[ai]} > now_q);
  assign st_o.ring_empty = fill_q == '0;
  assign st_o.pop_live = !done_q[pop_idx];
  assign st_o.admit_more = admit_avail;
  assign st_o.emit_done = emit_q >= CW'(N);

endmodule
`default_nettype wire

FILE: hdl/cpu_dispatch_scheduler.sv
`default_nettype none
// Load, restart and clear keep the controller idle; input stays ready.
// Dispatch, non-preemptive: a scan, a decide step and a commit precede the all-done sweep;
// an idle jump adds a rescan, and with nothing left there is no commit.
// Dispatch, round robin: arrived entries are admitted, dead pops skipped, each live pop runs
// up to one quantum, idle rings jump to the next arrival. One item at a time; the result holds
// until taken and input is ready the cycle after. Reset (async, active low): empty table.
module cpu_dispatch_scheduler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // cmd[1:0], proc_id[9:2], arrival[25:10], burst[41:26], prio[49:42]
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[0], slice_proc[8:1], slice_start[29:9], slice_end[50:30], finished[51],
  // turnaround[72:52], waiting[93:73], all_done[94]
  output logic [95:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic [1:0]  mode_q;
  logic [15:0] quantum_q;
  logic        vld_q;
  logic        in_ready, in_fire;
  cds_pkg::cmd_t    cmd;
  cds_pkg::status_t st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cds_pkg::MODE_FCFS;
      quantum_q <= 16'd2;
      vld_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_addr_i == cds_pkg::CFG_MODE) mode_q <= cfg_wdata_i[1:0];
      if (cfg_we_i && cfg_addr_i == cds_pkg::CFG_QUANTUM) quantum_q <= cfg_wdata_i;
      if (cmd.out_load) vld_q <= 1'b1;
      else if (m_axis_tready) vld_q <= 1'b0;
    end
  end

  assign in_fire = s_axis_tvalid && in_ready;
  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = vld_q;

  cds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .cmd_i      (s_axis_tdata[1:0]),
    .rr_mode_i  (mode_q == cds_pkg::MODE_RR),
    .out_busy_i (vld_q && !m_axis_tready),
    .st_i       (st),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  cds_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .mode_i    (mode_q),
    .quantum_i (quantum_q),
    .proc_id_i (s_axis_tdata[9:2]),
    .arrival_i (s_axis_tdata[25:10]),
    .burst_i   (s_axis_tdata[41:26]),
    .prio_i    (s_axis_tdata[49:42]),
    .st_o      (st),
    .result_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire
